/* hdl/erx_afc_pkg.sv */
// constants, codes and helpers for the receive address filter cam
// no dependencies; used by ethernet_rx_address_filter_cam
`timescale 1ns / 1ps

package erx_afc_pkg;

  // field widths
  localparam int unsigned IndexW    = 4;
  localparam int unsigned WordW     = 16;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned LenW      = 11;
  localparam int unsigned ReasonW   = 2;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // stream packing: tdata widths rounded up to whole bytes
  localparam int unsigned InFieldsW  = IndexW + 3 * WordW + AddrW + LenW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 3 + ReasonW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // store size
  localparam int unsigned EntryCountDefault = 16;

  // length limits, bytes
  localparam int unsigned MaxFrameBytes = 1518;
  localparam int unsigned MinFrameBytes = 64;
  localparam int unsigned FcsBytes      = 4;

  // address constants
  localparam logic [AddrW-1:0] BcastAddr = {AddrW{1'b1}};
  localparam int unsigned      GroupBit  = 40;

  // item kinds
  localparam logic KindLoad  = 1'b0;
  localparam logic KindCheck = 1'b1;

  // reject reasons
  localparam logic [ReasonW-1:0] ReasonNone   = 2'd0;
  localparam logic [ReasonW-1:0] ReasonLength = 2'd1;
  localparam logic [ReasonW-1:0] ReasonMiss   = 2'd2;
  localparam logic [ReasonW-1:0] ReasonRunt   = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgPromisc   = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgAllMcast  = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgBcast     = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgRunts     = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgEntryMask = 3'd4;

  // descriptor word byte swap
  function automatic logic [WordW-1:0] swap16(input logic [WordW-1:0] w);
    swap16 = {w[7:0], w[15:8]};
  endfunction

endpackage

/* hdl/ethernet_rx_address_filter_cam.sv */
// receive destination address filter with a small address cam
// depends on erx_afc_pkg
`timescale 1ns / 1ps

// usage
//   s_axis: one request per item. tuser is the kind: load writes one cam
//   entry from three byte-swapped descriptor words and gives no result;
//   check filters a frame's destination address and length and gives one
//   verdict on m_axis.
//   cfg: register writes (index, data), always ready; write only while the
//   block is idle.
// throughput
//   one item per cycle while no check waits on a stalled m_axis. a check
//   request is taken into the input register, and the up to 16-way compare
//   and verdict logic fill the result register from it. loads retire in the
//   input stage.
// reset
//   clears all cam entries and config registers to zero and empties both
//   stages. cam entries at or above 16 cannot be loaded or matched, so only
//   the first min(ENTRY_COUNT, 16) entries are built.
// back pressure
//   while m_axis is stalled with a verdict pending, a check in the input
//   register waits and s_axis_tready_o drops; a load still retires.
module ethernet_rx_address_filter_cam #(
  parameter int unsigned ENTRY_COUNT = erx_afc_pkg::EntryCountDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // entry_index[3:0], word_high[19:4], word_middle[35:20], word_low[51:36],
  // dest_address[99:52], frame_length[110:100], zero pad
  input  logic [erx_afc_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind[0]
  input  logic                               s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // accepted[0], broadcast_hit[1], multicast_hit[2], reject_reason[4:3], zero pad
  output logic [erx_afc_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [erx_afc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [erx_afc_pkg::CfgDataW-1:0]   cfg_data_i
);

  // entries the 4-bit index and 16-bit mask can reach
  localparam int unsigned LiveCount = (ENTRY_COUNT < 16) ? ENTRY_COUNT : 16;
  localparam int unsigned CntW      = erx_afc_pkg::LenW + 1;

  // config registers
  logic                              promisc_q;
  logic                              all_mcast_q;
  logic                              bcast_q;
  logic                              runts_q;
  logic [erx_afc_pkg::MaskW-1:0]     entry_mask_q;

  // input register
  logic                              s1_valid_q;
  logic                              s1_kind_q;
  logic [erx_afc_pkg::IndexW-1:0]    s1_index_q;
  logic [erx_afc_pkg::WordW-1:0]     s1_word_hi_q;
  logic [erx_afc_pkg::WordW-1:0]     s1_word_mid_q;
  logic [erx_afc_pkg::WordW-1:0]     s1_word_lo_q;
  logic [erx_afc_pkg::AddrW-1:0]     s1_addr_q;
  logic [erx_afc_pkg::LenW-1:0]      s1_len_q;

  // address cam
  logic [erx_afc_pkg::AddrW-1:0]     cam_q [LiveCount];
  logic [erx_afc_pkg::AddrW-1:0]     load_addr;
  logic [LiveCount-1:0]              hit_vec;

  // result register
  logic                              out_valid_q;
  logic                              out_accepted_q;
  logic                              out_bcast_q;
  logic                              out_mcast_q;
  logic [erx_afc_pkg::ReasonW-1:0]   out_reason_q;

  // handshake
  logic                              out_free;
  logic                              s1_advance;
  logic                              in_take;
  logic                              s1_load;
  logic                              s1_check_go;

  // verdict logic
  logic                              len_bad;
  logic                              is_bcast;
  logic                              is_group;
  logic                              cam_hit;
  logic [CntW-1:0]                   len_fcs;
  logic                              is_runt;
  logic                              v_ok;
  logic                              v_bcast;
  logic                              v_mcast;
  logic [erx_afc_pkg::ReasonW-1:0]   v_reason;

  // ---------------------------------------------------------------------------
  // handshake: loads always retire, checks need a free result register
  // ---------------------------------------------------------------------------
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_load         = s1_valid_q && (s1_kind_q == erx_afc_pkg::KindLoad);
  assign s1_check_go     = s1_valid_q && (s1_kind_q == erx_afc_pkg::KindCheck) && out_free;
  assign s1_advance      = s1_load || s1_check_go;
  assign s_axis_tready_o = !s1_valid_q || s1_advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      promisc_q    <= 1'b0;
      all_mcast_q  <= 1'b0;
      bcast_q      <= 1'b0;
      runts_q      <= 1'b0;
      entry_mask_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        erx_afc_pkg::CfgPromisc:   promisc_q    <= cfg_data_i[0];
        erx_afc_pkg::CfgAllMcast:  all_mcast_q  <= cfg_data_i[0];
        erx_afc_pkg::CfgBcast:     bcast_q      <= cfg_data_i[0];
        erx_afc_pkg::CfgRunts:     runts_q      <= cfg_data_i[0];
        erx_afc_pkg::CfgEntryMask: entry_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q     <= s_axis_tuser_i;
      s1_index_q    <= s_axis_tdata_i[3:0];
      s1_word_hi_q  <= s_axis_tdata_i[19:4];
      s1_word_mid_q <= s_axis_tdata_i[35:20];
      s1_word_lo_q  <= s_axis_tdata_i[51:36];
      s1_addr_q     <= s_axis_tdata_i[99:52];
      s1_len_q      <= s_axis_tdata_i[110:100];
    end
  end

  // ---------------------------------------------------------------------------
  // address cam: parallel compare, one entry written per load
  // ---------------------------------------------------------------------------
  assign load_addr = {erx_afc_pkg::swap16(s1_word_hi_q),
                      erx_afc_pkg::swap16(s1_word_mid_q),
                      erx_afc_pkg::swap16(s1_word_lo_q)};

  for (genvar g = 0; g < LiveCount; g++) begin : g_entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cam_q[g] <= '0;
      end else if (s1_load && (s1_index_q == erx_afc_pkg::IndexW'(g))) begin
        cam_q[g] <= load_addr;
      end
    end

    assign hit_vec[g] = entry_mask_q[g] && (cam_q[g] == s1_addr_q);
  end

  assign cam_hit = |hit_vec;

  // ---------------------------------------------------------------------------
  // verdict: length, then promiscuous, broadcast, group, cam, then runt
  // ---------------------------------------------------------------------------
  assign len_bad  = (s1_len_q == '0) ||
                    (s1_len_q > erx_afc_pkg::LenW'(erx_afc_pkg::MaxFrameBytes));
  assign is_bcast = (s1_addr_q == erx_afc_pkg::BcastAddr);
  assign is_group = s1_addr_q[erx_afc_pkg::GroupBit];
  assign len_fcs  = {1'b0, s1_len_q} + CntW'(erx_afc_pkg::FcsBytes);
  assign is_runt  = (len_fcs < CntW'(erx_afc_pkg::MinFrameBytes)) && !runts_q;

  always_comb begin
    v_ok     = 1'b0;
    v_bcast  = 1'b0;
    v_mcast  = 1'b0;
    v_reason = erx_afc_pkg::ReasonNone;
    if (len_bad) begin
      v_reason = erx_afc_pkg::ReasonLength;
    end else begin
      if (promisc_q) begin
        v_ok = 1'b1;
      end else if (is_bcast && (all_mcast_q || bcast_q)) begin
        v_ok    = 1'b1;
        v_bcast = 1'b1;
      end else if (is_group && all_mcast_q) begin
        v_ok    = 1'b1;
        v_mcast = 1'b1;
      end else if (cam_hit) begin
        v_ok = 1'b1;
      end
      if (!v_ok) begin
        v_reason = erx_afc_pkg::ReasonMiss;
      end else if (is_runt) begin
        // hit flags stay visible on a runt
        v_ok     = 1'b0;
        v_reason = erx_afc_pkg::ReasonRunt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_check_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_check_go) begin
      out_accepted_q <= v_ok;
      out_bcast_q    <= v_bcast;
      out_mcast_q    <= v_mcast;
      out_reason_q   <= v_reason;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(erx_afc_pkg::OutDataW - erx_afc_pkg::OutFieldsW){1'b0}},
                            out_reason_q, out_mcast_q, out_bcast_q, out_accepted_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> (out_valid_q == $past(out_valid_q && !m_axis_tready_i)))
    else $error("load request produced a result");

  // accepted exactly when no reject reason
  a_ok_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_accepted_q == (out_reason_q == erx_afc_pkg::ReasonNone)))
    else $error("accepted flag disagrees with reject reason");

  // length or address rejects carry no hit flags
  a_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_reason_q == erx_afc_pkg::ReasonLength ||
                     out_reason_q == erx_afc_pkg::ReasonMiss))
      |-> (!out_bcast_q && !out_mcast_q))
    else $error("hit flag set on a length or miss reject");

  // broadcast and multicast are exclusive
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_bcast_q && out_mcast_q))
    else $error("broadcast and multicast both set");

endmodule
